// ----- rtl/lbm_pkg.sv -----
package lbm_pkg;

  localparam int BINS        = 32;
  localparam int SEGMENTS    = 16;
  localparam int CURVE_DEPTH = 1024;

  localparam int CURVE_IDX_W = $clog2(CURVE_DEPTH);
  localparam int CURVE_W     = 16;
  localparam int BIN_IDX_W   = (BINS > 1) ? $clog2(BINS) : 1;
  localparam int SEG_W       = $clog2(SEGMENTS);
  localparam int LIT_W       = $clog2(SEGMENTS + 1);
  localparam int CFG_ADDR_W  = 4;

  localparam int LIT_DEN     = 10 * SEGMENTS;

  localparam logic [1:0] REG_ATTACK  = 2'd0;
  localparam logic [1:0] REG_RELEASE = 2'd1;
  localparam logic [1:0] REG_DECAY   = 2'd2;
  localparam logic [1:0] REG_BOOST   = 2'd3;

  localparam logic [8:0] ATTACK_RST  = 9'd154;
  localparam logic [8:0] RELEASE_RST = 9'd36;
  localparam logic [9:0] DECAY_RST   = 10'd14;
  localparam logic [7:0] BOOST_RST   = 8'd20;

  localparam logic [2:0] KIND_DIM   = 3'd0;
  localparam logic [2:0] KIND_LIT   = 3'd1;
  localparam logic [2:0] KIND_HOT   = 3'd2;
  localparam logic [2:0] KIND_PEAK  = 3'd3;
  localparam logic [2:0] KIND_TRAIL = 3'd4;

  localparam logic [7:0] PEAK_BRIGHT = 8'd217;
  localparam int         DIM_FLOOR   = 64;

  typedef struct packed {
    logic [4:0]  bin;
    logic [15:0] magnitude;
    logic [9:0]  elapsed_ms;
    logic [7:0]  hit;
  } in_item_t;

  typedef struct packed {
    logic [5:0] segment;
    logic [2:0] kind;
    logic [7:0] brightness;
    logic [6:0] lit_count;
    logic [5:0] peak_segment;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [8:0] attack_coef;
    logic [8:0] release_coef;
    logic [9:0] peak_decay_per_ms;
    logic [7:0] hit_boost_coef;
  } cfg_t;

  // one classified bin update between the front and back parts
  typedef struct packed {
    logic [BIN_IDX_W-1:0] bin;
    logic [CURVE_W-1:0]   shaped;
    logic [9:0]           elapsed_ms;
    logic [7:0]           hit;
  } cmd_t;

  // x^1.1 entry: largest r with r^10 <= x, then x*r in Q16
  function automatic logic [CURVE_W-1:0] curve_entry(longint unsigned i);
    longint unsigned x;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    longint unsigned r2;
    longint unsigned r4;
    longint unsigned r8;
    longint unsigned p;
    longint unsigned y;
    x  = (i * 64'd65536) / (CURVE_DEPTH - 1);
    lo = 0;
    hi = 65536;
    for (int k = 0; k < 20; k++) begin
      if (lo < hi) begin
        mid = (lo + hi + 1) >> 1;
        r2  = (mid * mid) >> 16;
        r4  = (r2 * r2) >> 16;
        r8  = (r4 * r4) >> 16;
        p   = (r8 * r2) >> 16;
        if (p <= x) lo = mid;
        else hi = mid - 1;
      end
    end
    y = (x * lo + 64'd32768) >> 16;
    if (y > 64'd65535) y = 64'd65535;
    return y[CURVE_W-1:0];
  endfunction

  function automatic logic [CURVE_DEPTH*CURVE_W-1:0] build_curve();
    logic [CURVE_DEPTH*CURVE_W-1:0] rom;
    rom = '0;
    for (int i = 0; i < CURVE_DEPTH; i++) begin
      rom[i*CURVE_W +: CURVE_W] = curve_entry(longint'(i));
    end
    return rom;
  endfunction

  function automatic logic [SEGMENTS*8-1:0] build_lit_bright();
    logic [SEGMENTS*8-1:0] tab;
    longint unsigned num;
    longint unsigned b;
    tab = '0;
    for (int j = 0; j < SEGMENTS; j++) begin
      num = 64'd255 * (64'd7 * SEGMENTS + 64'd3 * longint'(j));
      b   = (num * 2 + LIT_DEN) / (2 * LIT_DEN);
      if (b > 64'd255) b = 64'd255;
      tab[j*8 +: 8] = b[7:0];
    end
    return tab;
  endfunction

  function automatic logic [SEGMENTS*8-1:0] build_dim_bright();
    logic [SEGMENTS*8-1:0] tab;
    longint unsigned num;
    longint unsigned b;
    tab = '0;
    for (int j = 0; j < SEGMENTS; j++) begin
      num = 64'd255 * longint'(SEGMENTS - j);
      b   = (num * 2 + SEGMENTS) / (2 * SEGMENTS);
      if (b < DIM_FLOOR) b = DIM_FLOOR;
      if (b > 64'd255) b = 64'd255;
      tab[j*8 +: 8] = b[7:0];
    end
    return tab;
  endfunction

  // trail brightness by span d (peak minus lit) and offset n past the lit part:
  // floor((1022*d - 663*n) / (4*d)), found by counting
  function automatic logic [SEGMENTS*SEGMENTS*8-1:0] build_trail_bright();
    logic [SEGMENTS*SEGMENTS*8-1:0] tab;
    longint unsigned num;
    longint unsigned b;
    tab = '0;
    for (int d = 1; d < SEGMENTS; d++) begin
      for (int n = 0; n < d; n++) begin
        num = 64'd1022 * longint'(d) - 64'd663 * longint'(n);
        b   = 0;
        for (int k = 1; k < 256; k++) begin
          if (64'd4 * longint'(d) * longint'(k) <= num) b = longint'(k);
        end
        tab[(d*SEGMENTS + n)*8 +: 8] = b[7:0];
      end
    end
    return tab;
  endfunction

  localparam logic [CURVE_DEPTH*CURVE_W-1:0]  CURVE_ROM    = build_curve();
  localparam logic [SEGMENTS*8-1:0]           LIT_BRIGHT   = build_lit_bright();
  localparam logic [SEGMENTS*8-1:0]           DIM_BRIGHT   = build_dim_bright();
  localparam logic [SEGMENTS*SEGMENTS*8-1:0]  TRAIL_BRIGHT = build_trail_bright();

endpackage

// ----- rtl/lbm_regs.sv -----
module lbm_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [lbm_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  output lbm_pkg::cfg_t                    cfg
);

  lbm_pkg::cfg_t cfg_r;
  logic          wr_en;
  logic [1:0]    reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[3:2];
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.attack_coef       <= lbm_pkg::ATTACK_RST;
      cfg_r.release_coef      <= lbm_pkg::RELEASE_RST;
      cfg_r.peak_decay_per_ms <= lbm_pkg::DECAY_RST;
      cfg_r.hit_boost_coef    <= lbm_pkg::BOOST_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        lbm_pkg::REG_ATTACK:  cfg_r.attack_coef       <= pwdata[8:0];
        lbm_pkg::REG_RELEASE: cfg_r.release_coef      <= pwdata[8:0];
        lbm_pkg::REG_DECAY:   cfg_r.peak_decay_per_ms <= pwdata[9:0];
        lbm_pkg::REG_BOOST:   cfg_r.hit_boost_coef    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      lbm_pkg::REG_ATTACK:  prdata = {23'd0, cfg_r.attack_coef};
      lbm_pkg::REG_RELEASE: prdata = {23'd0, cfg_r.release_coef};
      lbm_pkg::REG_DECAY:   prdata = {22'd0, cfg_r.peak_decay_per_ms};
      lbm_pkg::REG_BOOST:   prdata = {24'd0, cfg_r.hit_boost_coef};
      default:              prdata = '0;
    endcase
  end

endmodule

// ----- rtl/lbm_front.sv -----
module lbm_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  lbm_pkg::in_item_t in_data,
  output logic              q_wr,
  output lbm_pkg::cmd_t     q_wdata,
  input  logic              q_full
);

  logic                              s1_v_r;
  lbm_pkg::cmd_t                     s1_cmd_r;
  logic                              accept;
  logic                              in_range;
  logic [lbm_pkg::CURVE_IDX_W-1:0]   curve_idx;

  assign full     = s1_v_r && q_full;
  assign accept   = push && !full;
  assign in_range = 32'(in_data.bin) < lbm_pkg::BINS;
  assign curve_idx = lbm_pkg::CURVE_IDX_W'(
                       (32'(in_data.magnitude) * 32'(lbm_pkg::CURVE_DEPTH)) >> 16);

  assign q_wr    = s1_v_r && !q_full;
  assign q_wdata = s1_cmd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (accept && in_range) begin
      s1_v_r <= 1'b1;
    end else if (q_wr) begin
      s1_v_r <= 1'b0;
    end
  end

  // registered curve lookup; out-of-range bins are dropped here
  always_ff @(posedge clk) begin
    if (accept && in_range) begin
      s1_cmd_r.bin        <= lbm_pkg::BIN_IDX_W'(in_data.bin);
      s1_cmd_r.shaped     <= lbm_pkg::CURVE_ROM[32'(curve_idx) * lbm_pkg::CURVE_W
                                                +: lbm_pkg::CURVE_W];
      s1_cmd_r.elapsed_ms <= in_data.elapsed_ms;
      s1_cmd_r.hit        <= in_data.hit;
    end
  end

endmodule

// ----- rtl/lbm_cmd_q.sv -----
module lbm_cmd_q (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  lbm_pkg::cmd_t wr_data,
  output logic          full,
  input  logic          rd_en,
  output lbm_pkg::cmd_t rd_data,
  output logic          empty
);

  lbm_pkg::cmd_t slot_r [2];
  logic          wp_r;
  logic          rp_r;
  logic [1:0]    cnt_r;
  logic          do_wr;
  logic          do_rd;

  assign full    = cnt_r == 2'd2;
  assign empty   = cnt_r == 2'd0;
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_wr) wp_r <= !wp_r;
      if (do_rd) rp_r <= !rp_r;
      if (do_wr && !do_rd) cnt_r <= cnt_r + 2'd1;
      else if (do_rd && !do_wr) cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) slot_r[wp_r] <= wr_data;
  end

endmodule

// ----- rtl/lbm_back.sv -----
module lbm_back (
  input  logic               clk,
  input  logic               rst_n,
  input  lbm_pkg::cfg_t      cfg,
  input  logic               q_empty,
  input  lbm_pkg::cmd_t      q_data,
  output logic               q_rd,
  output logic               empty,
  input  logic               pop,
  output lbm_pkg::out_item_t out_data
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_MUL   = 4'd1;
  localparam logic [3:0] ST_LVL   = 4'd2;
  localparam logic [3:0] ST_PEAK  = 4'd3;
  localparam logic [3:0] ST_HIT   = 4'd4;
  localparam logic [3:0] ST_DIV   = 4'd5;
  localparam logic [3:0] ST_FIX   = 4'd6;
  localparam logic [3:0] ST_SCALE = 4'd7;
  localparam logic [3:0] ST_HAND  = 4'd8;

  localparam int SEG_W = lbm_pkg::SEG_W;
  localparam int LIT_W = lbm_pkg::LIT_W;

  // ---------------- bin update sequencer ----------------
  logic [3:0]                     state_r;
  logic [15:0]                    level_store_r [lbm_pkg::BINS];
  logic [15:0]                    peak_store_r  [lbm_pkg::BINS];
  logic [lbm_pkg::BIN_IDX_W-1:0]  bin_r;
  logic [15:0]                    v_r;
  logic [9:0]                     ms_r;
  logic [7:0]                     hit_r;
  logic [15:0]                    lvl_r;
  logic [15:0]                    pk_r;
  logic                           up_r;
  logic [24:0]                    prod_r;
  logic [19:0]                    decay_r;
  logic [31:0]                    wide_r;
  logic [24:0]                    m_r;
  logic [17:0]                    qest_r;
  logic [15:0]                    lv_r;
  logic [LIT_W-1:0]               lit_r;
  logic [SEG_W-1:0]               pkseg_r;

  logic [8:0]   att_sat;
  logic [8:0]   rel_sat;
  logic [15:0]  diff;
  logic [15:0]  step;
  logic [15:0]  lvl_nxt;
  logic [15:0]  pk_dec;
  logic [15:0]  pk_nxt;
  logic [24:0]  m_c;
  logic [33:0]  qprod;
  logic [25:0]  rem;
  logic [17:0]  q_fix;
  logic [18:0]  lv_sum;
  logic [31:0]  lit_raw;
  logic [31:0]  pk_raw;
  logic [7:0]   den_c;
  logic         hand;

  logic              e_busy_r;
  logic [SEG_W-1:0]  e_j_r;
  logic [LIT_W-1:0]  e_lit_r;
  logic [SEG_W-1:0]  e_pk_r;
  logic [SEG_W-1:0]  e_den_r;

  assign att_sat = (cfg.attack_coef > 9'd256) ? 9'd256 : cfg.attack_coef;
  assign rel_sat = (cfg.release_coef > 9'd256) ? 9'd256 : cfg.release_coef;
  assign diff    = (v_r > lvl_r) ? (v_r - lvl_r) : (lvl_r - v_r);
  // weight never exceeds 1.0, so the step stays within the distance
  assign step    = 16'((prod_r + 25'd128) >> 8);
  assign lvl_nxt = up_r ? (lvl_r + step) : (lvl_r - step);
  assign pk_dec  = (20'(pk_r) > decay_r) ? (pk_r - 16'(decay_r)) : 16'd0;
  assign pk_nxt  = (pk_dec < lvl_r) ? lvl_r : pk_dec;

  // round(x/65280) as floor(floor((x+32640)/256)/255), reciprocal plus one fix-up
  assign m_c     = 25'((33'(wide_r) + 33'd32640) >> 8);
  assign qprod   = 34'(m_c) * 34'd257;
  assign rem     = 26'(m_r) - (26'(qest_r) * 26'd255);
  assign q_fix   = qest_r + 18'(rem >= 26'd255);
  assign lv_sum  = 19'(lvl_r) + 19'(q_fix);

  assign lit_raw = (32'(lv_r) * 32'(lbm_pkg::SEGMENTS) + 32'd32768) >> 16;
  assign pk_raw  = (32'(pk_r) * 32'(lbm_pkg::SEGMENTS) + 32'd32768) >> 16;

  assign den_c   = (8'(pkseg_r) > 8'(lit_r)) ? (8'(pkseg_r) - 8'(lit_r)) : 8'd0;
  assign hand    = (state_r == ST_HAND) && !e_busy_r;
  assign q_rd    = (state_r == ST_IDLE) && !q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      for (int b = 0; b < lbm_pkg::BINS; b++) begin
        level_store_r[b] <= '0;
        peak_store_r[b]  <= '0;
      end
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (!q_empty) state_r <= ST_MUL;
        end
        ST_MUL:   state_r <= ST_LVL;
        ST_LVL: begin
          level_store_r[bin_r] <= lvl_nxt;
          state_r <= ST_PEAK;
        end
        ST_PEAK: begin
          peak_store_r[bin_r] <= pk_nxt;
          state_r <= ST_HIT;
        end
        ST_HIT:   state_r <= ST_DIV;
        ST_DIV:   state_r <= ST_FIX;
        ST_FIX:   state_r <= ST_SCALE;
        ST_SCALE: state_r <= ST_HAND;
        ST_HAND: begin
          if (!e_busy_r) state_r <= ST_IDLE;
        end
        default:  state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        bin_r <= q_data.bin;
        v_r   <= q_data.shaped;
        ms_r  <= q_data.elapsed_ms;
        hit_r <= q_data.hit;
        lvl_r <= level_store_r[q_data.bin];
        pk_r  <= peak_store_r[q_data.bin];
      end
      ST_MUL: begin
        up_r    <= v_r > lvl_r;
        prod_r  <= 25'(diff) * 25'((v_r > lvl_r) ? att_sat : rel_sat);
        decay_r <= 20'(ms_r) * 20'(cfg.peak_decay_per_ms);
      end
      ST_LVL: lvl_r <= lvl_nxt;
      ST_PEAK: begin
        pk_r   <= pk_nxt;
        wide_r <= 32'(lvl_r) * 32'(cfg.hit_boost_coef);
      end
      ST_HIT: wide_r <= 32'(wide_r[23:0]) * 32'(hit_r);
      ST_DIV: begin
        m_r    <= m_c;
        qest_r <= 18'(qprod >> 16);
      end
      ST_FIX: lv_r <= (lv_sum > 19'd65535) ? 16'hFFFF : lv_sum[15:0];
      ST_SCALE: begin
        lit_r   <= LIT_W'(lit_raw);
        pkseg_r <= (pk_raw > 32'(lbm_pkg::SEGMENTS - 1)) ?
                   SEG_W'(lbm_pkg::SEGMENTS - 1) : SEG_W'(pk_raw);
      end
      default: ;
    endcase
  end

  // ---------------- segment emitter ----------------
  logic                e1_v_r;
  lbm_pkg::out_item_t  e1_item_r;

  lbm_pkg::out_item_t  oq_r [4];
  logic [1:0]          oq_wp_r;
  logic [1:0]          oq_rp_r;
  logic [2:0]          oq_cnt_r;

  logic                issue;
  logic                e_last;
  logic [LIT_W-1:0]    jx;
  logic [SEG_W-1:0]    n_c;
  logic [2:0]          kind_c;
  logic [7:0]          bright_c;
  logic                oq_pop;

  assign issue  = e_busy_r && ((oq_cnt_r + 3'(e1_v_r)) < 3'd4);
  assign e_last = e_j_r == SEG_W'(lbm_pkg::SEGMENTS - 1);
  assign jx     = LIT_W'(e_j_r);
  assign n_c    = SEG_W'(jx - e_lit_r);

  always_comb begin
    if (jx < e_lit_r) begin
      kind_c   = (jx + LIT_W'(1) == e_lit_r) ? lbm_pkg::KIND_HOT : lbm_pkg::KIND_LIT;
      bright_c = lbm_pkg::LIT_BRIGHT[32'(e_j_r) * 8 +: 8];
    end else if ((e_j_r == e_pk_r) && (e_pk_r != '0)) begin
      kind_c   = lbm_pkg::KIND_PEAK;
      bright_c = lbm_pkg::PEAK_BRIGHT;
    end else if (e_j_r < e_pk_r) begin
      // look up by span to the peak and offset past the lit part
      kind_c   = lbm_pkg::KIND_TRAIL;
      bright_c = lbm_pkg::TRAIL_BRIGHT[(32'(e_den_r) * lbm_pkg::SEGMENTS + 32'(n_c)) * 8
                                       +: 8];
    end else begin
      kind_c   = lbm_pkg::KIND_DIM;
      bright_c = lbm_pkg::DIM_BRIGHT[32'(e_j_r) * 8 +: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_busy_r <= 1'b0;
      e_j_r    <= '0;
      e1_v_r   <= 1'b0;
    end else begin
      e1_v_r <= issue;
      if (hand) begin
        e_busy_r <= 1'b1;
        e_j_r    <= '0;
      end else if (issue) begin
        e_j_r <= e_j_r + SEG_W'(1);
        if (e_last) e_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hand) begin
      e_lit_r <= lit_r;
      e_pk_r  <= pkseg_r;
      e_den_r <= SEG_W'(den_c);
    end
    if (issue) begin
      e1_item_r.segment      <= 6'(e_j_r);
      e1_item_r.kind         <= kind_c;
      e1_item_r.brightness   <= bright_c;
      e1_item_r.lit_count    <= 7'(e_lit_r);
      e1_item_r.peak_segment <= 6'(e_pk_r);
      e1_item_r.last         <= e_last;
    end
  end

  // output queue: issue only with a free slot for the beat in flight
  assign empty    = oq_cnt_r == 3'd0;
  assign oq_pop   = pop && !empty;
  assign out_data = oq_r[oq_rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wp_r  <= '0;
      oq_rp_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      if (e1_v_r) oq_wp_r <= oq_wp_r + 2'd1;
      if (oq_pop) oq_rp_r <= oq_rp_r + 2'd1;
      if (e1_v_r && !oq_pop) oq_cnt_r <= oq_cnt_r + 3'd1;
      else if (oq_pop && !e1_v_r) oq_cnt_r <= oq_cnt_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (e1_v_r) oq_r[oq_wp_r] <= e1_item_r;
  end

endmodule

// ----- rtl/led_bar_meter_peak_hold_top.sv -----
// LED bar level meter with peak hold. Each accepted item updates one bin's
// smoothed level and decaying peak hold and then yields 16 result beats, one per
// segment from the inner end, the final one flagged by last. The front shapes the
// magnitude through a registered 1024-entry curve ROM and drops items whose bin is
// out of range (no results); a two-entry queue feeds the back part, whose update
// sequencer steps through idle, mul, lvl, peak, hit, div, fix, scale and hand and
// overlaps with the segment emitter of the previous item. The emitter paces the
// results: a load, then one beat per segment while pop keeps up. Registers sit at
// byte addresses 0, 4, 8 and 12 (attack, release, peak decay per ms, hit boost);
// the user must write them only while the block is idle, which the block itself
// does not enforce.
module led_bar_meter_peak_hold_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  output logic                            full,
  input  lbm_pkg::in_item_t               in_data,
  output logic                            empty,
  input  logic                            pop,
  output lbm_pkg::out_item_t              out_data,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lbm_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  lbm_pkg::cfg_t cfg;
  lbm_pkg::cmd_t q_wdata;
  lbm_pkg::cmd_t q_rdata;
  logic          q_wr;
  logic          q_full;
  logic          q_rd;
  logic          q_empty;

  lbm_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lbm_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_data (in_data),
    .q_wr    (q_wr),
    .q_wdata (q_wdata),
    .q_full  (q_full)
  );

  lbm_cmd_q u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_wr),
    .wr_data (q_wdata),
    .full    (q_full),
    .rd_en   (q_rd),
    .rd_data (q_rdata),
    .empty   (q_empty)
  );

  lbm_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .q_empty  (q_empty),
    .q_data   (q_rdata),
    .q_rd     (q_rd),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

endmodule
